/* hdl/compacting_list_store_macros.svh */
// assertion helpers for the rtl files (included by cls_seq)
`ifndef COMPACTING_LIST_STORE_MACROS_SVH
`define COMPACTING_LIST_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only out of reset
`define CLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define CLS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CLS_ASSERT(lbl, prop, msg)
`define CLS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* hdl/cls_pkg.sv */
`default_nettype none

package cls_pkg;

    localparam int CAPACITY_DEF = 256;

    // opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
        logic [7:0]         index;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [8:0]         removed_count;
        logic [8:0]         live_count;
    } res_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET,
        S_SCAN,
        S_DONE
    } state_t;

    // top to sequencer
    typedef struct packed {
        logic start;
        logic ack;
    } seq_ctl_t;

    // sequencer to top
    typedef struct packed {
        logic idle;
        logic done;
        res_t item;
    } seq_rsp_t;

endpackage

`default_nettype wire

/* hdl/compacting_list_store.sv */
// path: append, get miss and unused opcodes go from idle straight to done, a get hit
//   passes through the store read state first, and remove scans the store (one store read
//   per cycle, each entry that does not match the key written back in compacted order)
// throughput: one beat per operation; the next beat is taken the cycle after the previous
//   result has moved into the output register, which waits while that register is full
// reset: rst_n clears the live count and all handshake state; store contents are
//   not cleared and hold anything until written
`default_nettype none

module compacting_list_store #(
    parameter int CAPACITY = cls_pkg::CAPACITY_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // command channel
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire cls_pkg::cmd_t cmd,
    // result channel
    output logic               res_valid,
    input  wire logic          res_ready,
    output cls_pkg::res_t      res
);

    cls_pkg::seq_ctl_t ctl;
    cls_pkg::seq_rsp_t rsp;

    logic              res_valid_reg, res_valid_next;
    cls_pkg::res_t     res_reg, res_next;
    logic              take;

    // sequencer: store, live count, compare and scan pointers
    cls_seq #(
        .CAPACITY(CAPACITY)
    ) u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .cmd  (cmd),
        .rsp  (rsp)
    );

    // a command beat is taken whenever the sequencer sits idle
    assign cmd_ready = rsp.idle;
    assign ctl.start = cmd_valid && cmd_ready;

    // move a finished result into the output register when it is free or draining
    assign take    = rsp.done && (!res_valid_reg || res_ready);
    assign ctl.ack = take;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (take)
        begin
            res_valid_next = 1'b1;
            res_next       = rsp.item;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* hdl/cls_seq.sv */
`default_nettype none

`include "compacting_list_store_macros.svh"

module cls_seq #(
    parameter int CAPACITY = cls_pkg::CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cls_pkg::seq_ctl_t ctl,
    input  wire cls_pkg::cmd_t     cmd,
    output cls_pkg::seq_rsp_t      rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    cls_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   wr_reg, wr_next;
    logic            pend_reg, pend_next;
    logic [31:0]     val_reg, val_next;
    cls_pkg::res_t   res_reg, res_next;

    // entry store
    logic [31:0]     mem [CAPACITY];
    logic [31:0]     rdata_reg;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [31:0]     wdata;
    logic            re;
    logic [AW-1:0]   raddr;

    logic            mismatch;
    logic [CW-1:0]   removed;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cls_pkg::S_IDLE;
            count_reg <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        res_reg <= res_next;
    end

    // compare of the fetched entry against the removal key
    assign mismatch = (rdata_reg != val_reg);
    assign removed  = count_reg - wr_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        pend_next  = pend_reg;
        val_next   = val_reg;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = wr_reg[AW-1:0];
        wdata      = rdata_reg;
        re         = 1'b0;
        raddr      = rd_reg[AW-1:0];

        case (state_reg)
            cls_pkg::S_IDLE:
            begin
                if (ctl.start)
                begin
                    res_next            = '0;
                    res_next.status     = cls_pkg::ST_OK;
                    res_next.live_count = 9'(count_reg);
                    state_next          = cls_pkg::S_DONE;
                    case (cmd.opcode)
                        cls_pkg::OP_APPEND:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                res_next.status = cls_pkg::ST_FULL;
                            end
                            else
                            begin
                                we                  = 1'b1;
                                waddr               = count_reg[AW-1:0];
                                wdata               = cmd.value;
                                count_next          = count_reg + CW'(1);
                                res_next.live_count = 9'(count_reg + CW'(1));
                            end
                        end
                        cls_pkg::OP_REMOVE:
                        begin
                            rd_next    = '0;
                            wr_next    = '0;
                            pend_next  = 1'b0;
                            val_next   = cmd.value;
                            state_next = cls_pkg::S_SCAN;
                        end
                        cls_pkg::OP_GET:
                        begin
                            if ((32'(cmd.index) >= 32'(count_reg)) ||
                                (32'(cmd.index) >= CAPACITY))
                            begin
                                res_next.status = cls_pkg::ST_BAD_INDEX;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = AW'(cmd.index);
                                state_next = cls_pkg::S_GET;
                            end
                        end
                        default:
                        begin
                            res_next.status = cls_pkg::ST_OK;
                        end
                    endcase
                end
            end

            cls_pkg::S_GET:
            begin
                res_next.read_value = rdata_reg;
                state_next          = cls_pkg::S_DONE;
            end

            cls_pkg::S_SCAN:
            begin
                // fetch side runs ahead of the compact side
                if (rd_reg != count_reg)
                begin
                    re        = 1'b1;
                    rd_next   = rd_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg && mismatch)
                begin
                    we      = 1'b1;
                    wr_next = wr_reg + CW'(1);
                end

                if ((rd_reg == count_reg) && !pend_reg)
                begin
                    count_next             = wr_reg;
                    res_next.removed_count = 9'(removed);
                    res_next.live_count    = 9'(wr_reg);
                    res_next.status        = (removed == '0) ? cls_pkg::ST_NOT_FOUND
                                                             : cls_pkg::ST_OK;
                    state_next             = cls_pkg::S_DONE;
                end
            end

            cls_pkg::S_DONE:
            begin
                if (ctl.ack)
                begin
                    state_next = cls_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = cls_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp.idle = (state_reg == cls_pkg::S_IDLE);
    assign rsp.done = (state_reg == cls_pkg::S_DONE);
    assign rsp.item = res_reg;

    `CLS_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "count above capacity")
    `CLS_ASSERT(a_wr_behind_rd, (state_reg == cls_pkg::S_SCAN) |-> (wr_reg <= rd_reg),
                "compact pointer ahead of fetch pointer")
    `CLS_ASSERT(a_scan_write, (we && (state_reg == cls_pkg::S_SCAN)) |-> (wr_reg < rd_reg),
                "compaction write not behind fetch")
    `CLS_ASSERT(a_start_idle, ctl.start |-> (state_reg == cls_pkg::S_IDLE),
                "start while busy")
    `CLS_ASSERT(a_done_count, (state_reg == cls_pkg::S_DONE) |->
                (res_reg.live_count == 9'(count_reg)), "reported count differs from state")

endmodule

`default_nettype wire
